// ----- design/mcd_pkg.sv -----
`default_nettype none

package mcd_pkg;

   // default number of debounced channels
   localparam int CHANNELS_DEFAULT = 5;

   // lockout register
   localparam int          LOCKOUT_W     = 8;
   localparam logic [7:0]  LOCKOUT_RESET = 8'd200;

   // item kinds on the request channel
   typedef enum logic {
      ACT_TICK = 1'b0,
      ACT_POLL = 1'b1
   } action_type;

   // width of a channel number for a given channel count
   function automatic int chan_idx_width(input int channels);
      return (channels > 1) ? $clog2(channels) : 1;
   endfunction

endpackage

`default_nettype wire

// ----- design/mcd_skid.sv -----
`default_nettype none

module mcd_skid
   import mcd_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [WIDTH-1:0] in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic      [WIDTH-1:0] out_data
);

   logic             out_valid_ff;
   logic             out_valid_in;
   logic [WIDTH-1:0] out_data_ff;
   logic [WIDTH-1:0] out_data_in;
   logic             skid_valid_ff;
   logic             skid_valid_in;
   logic [WIDTH-1:0] skid_data_ff;
   logic [WIDTH-1:0] skid_data_in;
   logic             in_xfer;
   logic             out_xfer;

   // the skid stage takes one transfer while the output waits
   assign in_ready  = !skid_valid_ff;
   assign in_xfer   = in_valid && !skid_valid_ff;
   assign out_xfer  = out_valid_ff && out_ready;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // next state of the output and skid registers
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_xfer) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_xfer) begin
         if (!out_valid_ff || out_xfer) begin
            out_valid_in = 1'b1;
            out_data_in  = in_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = in_data;
         end
      end else if (out_xfer) begin
         out_valid_in = 1'b0;
      end
   end

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

`default_nettype wire

// ----- design/multichannel_change_debouncer_top.sv -----
// each result is registered: it goes to the output register, or to the skid stage while the output is stalled
// one item per cycle while req_ready is high; a skid stage holds one result while rsp_ready is low
// the request side stalls only when both the output and the skid stage are full
// reset (synchronous, active high) clears committed levels, lockout counter and pending
// change, empties the result stages, and sets the lockout register to 200
`default_nettype none

module multichannel_change_debouncer_top
   import mcd_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT,
   localparam int CW = chan_idx_width(CHANNELS)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_action,
   input  wire logic [CHANNELS-1:0]  req_pin_levels,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_report_valid,
   output logic      [CW-1:0]        rsp_report_channel,
   output logic                      rsp_report_level,
   output logic      [CHANNELS-1:0]  rsp_stable_levels,
   output logic                      rsp_locked,
   input  wire logic                 csr_wr_en,
   input  wire logic [LOCKOUT_W-1:0] csr_wr_data
);

   localparam int RW = CW + CHANNELS + 3;

   logic [LOCKOUT_W-1:0] lockout_ticks_ff;
   logic [CHANNELS-1:0]  committed_ff;
   logic [CHANNELS-1:0]  committed_in;
   logic [LOCKOUT_W-1:0] count_ff;
   logic [LOCKOUT_W-1:0] count_in;
   logic                 pend_valid_ff;
   logic                 pend_valid_in;
   logic [CW-1:0]        pend_chan_ff;
   logic [CW-1:0]        pend_chan_in;
   logic                 pend_level_ff;
   logic                 pend_level_in;

   logic                 req_xfer;
   logic                 rep_valid;
   logic [CW-1:0]        rep_chan;
   logic                 rep_level;
   logic [CHANNELS-1:0]  after_commit;
   logic [CHANNELS-1:0]  diff;
   logic                 found;
   logic [CW-1:0]        found_chan;
   logic                 found_level;
   logic [RW-1:0]        result;
   logic [RW-1:0]        rsp_data;

   assign req_xfer = req_valid && req_ready;

   // lockout register
   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ticks_ff <= LOCKOUT_RESET;
      end else if (csr_wr_en) begin
         lockout_ticks_ff <= csr_wr_data;
      end
   end

   // committed levels after a possible commit of the pending change
   assign after_commit = pend_valid_ff
                       ? (committed_ff ^ (CHANNELS'(1) << pend_chan_ff))
                       : committed_ff;
   assign diff = req_pin_levels ^ after_commit;

   // lowest differing channel wins
   always_comb begin
      found       = 1'b0;
      found_chan  = '0;
      found_level = 1'b0;
      for (int i = CHANNELS - 1; i >= 0; i--) begin
         if (diff[i]) begin
            found       = 1'b1;
            found_chan  = CW'(i);
            found_level = req_pin_levels[i];
         end
      end
   end

   // next state and result for one item
   always_comb begin
      committed_in  = committed_ff;
      count_in      = count_ff;
      pend_valid_in = pend_valid_ff;
      pend_chan_in  = pend_chan_ff;
      pend_level_in = pend_level_ff;
      rep_valid     = 1'b0;
      rep_chan      = '0;
      rep_level     = 1'b0;
      if (req_action == ACT_TICK) begin
         if (count_ff != '0) begin
            count_in = count_ff - LOCKOUT_W'(1);
         end
      end else if (count_ff == '0) begin
         committed_in = after_commit;
         if (pend_valid_ff) begin
            rep_valid     = 1'b1;
            rep_chan      = pend_chan_ff;
            rep_level     = pend_level_ff;
            pend_valid_in = 1'b0;
         end
         if (found) begin
            pend_valid_in = 1'b1;
            pend_chan_in  = found_chan;
            pend_level_in = found_level;
            count_in      = lockout_ticks_ff;
         end
      end
   end

   // debouncer state, updated on each request transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         committed_ff  <= '0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         pend_chan_ff  <= '0;
         pend_level_ff <= 1'b0;
      end else if (req_xfer) begin
         committed_ff  <= committed_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         pend_chan_ff  <= pend_chan_in;
         pend_level_ff <= pend_level_in;
      end
   end

   assign result = {rep_valid, rep_chan, rep_level, committed_in, (count_in != '0)};

   // result register with skid stage
   mcd_skid #(
      .WIDTH(RW)
   ) u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (result),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign {rsp_report_valid, rsp_report_channel, rsp_report_level,
           rsp_stable_levels, rsp_locked} = rsp_data;

endmodule

`default_nettype wire

// ----- design/mcd_checker.sv -----
`default_nettype none

module mcd_checker
   import mcd_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEFAULT,
   localparam int CW = chan_idx_width(CHANNELS)
) (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic                 req_action,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic                 rsp_report_valid,
   input wire logic [CW-1:0]        rsp_report_channel,
   input wire logic                 rsp_report_level,
   input wire logic [CHANNELS-1:0]  rsp_stable_levels,
   input wire logic                 rsp_locked
);

   logic [CHANNELS-1:0] sel_shift;

   // committed level of the reported channel
   assign sel_shift = rsp_stable_levels >> rsp_report_channel;

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_stable_levels)
         && $stable(rsp_report_valid) && $stable(rsp_locked))
      else $error("stalled result changed");

   // no result right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

   // a reported channel exists and its committed level matches the report
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_report_valid |->
         (32'(rsp_report_channel) < CHANNELS) && (sel_shift[0] == rsp_report_level))
      else $error("report disagrees with committed levels");

   // no report means zero channel and level
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_report_valid |-> rsp_report_channel == '0 && !rsp_report_level)
      else $error("idle report fields not zero");

   // a tick never produces a report
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_action == ACT_TICK) && !rsp_valid
         |=> rsp_valid && !rsp_report_valid)
      else $error("tick produced a report");

endmodule

bind multichannel_change_debouncer_top mcd_checker #(.CHANNELS(CHANNELS)) u_mcd_checker (.*);

`default_nettype wire
